### rtl/pqr_pkg.sv
// Shared types and constants for the palette quantize run-length encoder.
`timescale 1ns / 1ps
`default_nettype none
package pqr_pkg;

    localparam int PAL_ENTRIES = 15;
    localparam int IDX_W       = 4;
    localparam int RGB_W       = 24;
    localparam int LEN_W       = 8;
    localparam int DIST_W      = 11;

    localparam logic [DIST_W-1:0] WEIGHT_START = DIST_W'(256 * 4);
    localparam logic [LEN_W-1:0]  MAX_LEN_4BIT = 8'h0F;
    localparam logic [LEN_W-1:0]  MAX_LEN_8BIT = 8'hFF;
    localparam logic [IDX_W-1:0]  PAL_LIMIT    = IDX_W'(PAL_ENTRIES);

    typedef enum logic [1:0] {
        REG_RLE_MODE    = 2'd0,
        REG_USE_TRANS   = 2'd1,
        REG_TRANS_COLOR = 2'd2,
        REG_PAL_COUNT   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_LEN,
        ST_IDX
    } enc_state_t;

    // Candidate that travels down the cell row.
    typedef struct packed {
        logic              vld;
        logic [RGB_W-1:0]  rgb;
        logic [DIST_W-1:0] best_w;
        logic [IDX_W-1:0]  best_idx;
    } srch_t;

    // Palette write bus shared by all cells.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] slot;
        logic [RGB_W-1:0] color;
    } pal_wr_t;

endpackage
`default_nettype wire

### rtl/pqr_cell.sv
// One palette cell: holds one entry and updates the passing nearest-color candidate.
`timescale 1ns / 1ps
`default_nettype none
module pqr_cell import pqr_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IDX_W-1:0] cell_id,
    input  wire logic [IDX_W-1:0] count,
    input  pal_wr_t               wr,
    input  srch_t                 srch_in,
    output srch_t                 srch_out
);

    logic [RGB_W-1:0] entry_reg;
    srch_t            srch_reg;
    srch_t            srch_next;
    logic [7:0]       dr, dg, db;
    logic [DIST_W-1:0] sad;

    always_comb begin
        dr = (entry_reg[23:16] > srch_in.rgb[23:16]) ? entry_reg[23:16] - srch_in.rgb[23:16]
                                                      : srch_in.rgb[23:16] - entry_reg[23:16];
        dg = (entry_reg[15:8] > srch_in.rgb[15:8]) ? entry_reg[15:8] - srch_in.rgb[15:8]
                                                    : srch_in.rgb[15:8] - entry_reg[15:8];
        db = (entry_reg[7:0] > srch_in.rgb[7:0]) ? entry_reg[7:0] - srch_in.rgb[7:0]
                                                  : srch_in.rgb[7:0] - entry_reg[7:0];
        sad = DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);
        srch_next = srch_in;
        // strict less-than keeps the lowest index on ties
        if (cell_id <= count && sad < srch_in.best_w) begin
            srch_next.best_w   = sad;
            srch_next.best_idx = cell_id;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.we && wr.slot == cell_id) begin
            entry_reg <= wr.color;
        end
        if (!aresetn) begin
            srch_reg.vld <= 1'b0;
        end else begin
            srch_reg.vld <= srch_next.vld;
        end
        srch_reg.rgb      <= srch_next.rgb;
        srch_reg.best_w   <= srch_next.best_w;
        srch_reg.best_idx <= srch_next.best_idx;
    end

    assign srch_out = srch_reg;

endmodule
`default_nettype wire

### rtl/pqr_chain.sv
// Row of palette cells, one candidate hop per cycle.
`timescale 1ns / 1ps
`default_nettype none
module pqr_chain import pqr_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [IDX_W-1:0] count,
    input  pal_wr_t               wr,
    input  srch_t                 srch_in,
    output srch_t                 srch_out
);

    srch_t link [0:PAL_ENTRIES];

    assign link[0] = srch_in;

    for (genvar k = 0; k < PAL_ENTRIES; k++) begin : g_cell
        pqr_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_id  (IDX_W'(k + 1)),
            .count    (count),
            .wr       (wr),
            .srch_in  (link[k]),
            .srch_out (link[k+1])
        );
    end

    assign srch_out = link[PAL_ENTRIES];

endmodule
`default_nettype wire

### rtl/palette_quantize_rle_encoder.sv
// Top level: run builder, emit sequencer and palette cell row.
//
//  channel | direction | payload
//  s_*     | in        | tdata: color[23:0], slot[27:24]; tuser: palette write; tlast: last_pixel
//  m_*     | out       | tdata: out_byte[7:0]; tuser: last_of_item; tlast: end_of_sprite
//  cfg_*   | in        | register write, index 0..3
//
// A palette write or a pixel that closes no run is taken without leaving the idle state.
// Each closed run passes the start state, then the palette cell row (skipped for
// a transparent hit), then emits its output bytes; a flush can close two runs.
// Reset is synchronous; palette entries are not cleared.
// A stalled output holds the sequencer in its byte state.
`timescale 1ns / 1ps
`default_nettype none
module palette_quantize_rle_encoder import pqr_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // color[23:0], slot[27:24], zero[31:28]
    input  wire logic        s_tuser,   // palette write
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte[7:0]
    output logic             m_tuser,   // last_of_item
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata
);

    logic             rle_mode_reg, use_trans_reg;
    logic [RGB_W-1:0] trans_color_reg;
    logic [IDX_W-1:0] pal_count_reg;

    logic [RGB_W-1:0] run_color_reg, run_color_next;
    logic [LEN_W-1:0] run_len_reg, run_len_next;
    logic             run_open_reg, run_open_next;

    logic [RGB_W-1:0] job_col_reg [0:1];
    logic [RGB_W-1:0] job_col_next [0:1];
    logic [LEN_W-1:0] job_len_reg [0:1];
    logic [LEN_W-1:0] job_len_next [0:1];
    logic [1:0]       job_vld_reg, job_vld_next;
    logic             cur_reg, cur_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    enc_state_t state_reg, state_next;

    logic       out_vld_reg, out_vld_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_loi_reg, out_loi_next;
    logic       out_eos_reg, out_eos_next;

    srch_t            inj;
    srch_t            res;
    pal_wr_t          wr;
    logic [IDX_W-1:0] count;
    logic             accept, out_free, final_job, extend;
    logic [LEN_W-1:0] max_len;
    logic [RGB_W-1:0] pix;
    logic [RGB_W-1:0] new_col;
    logic [LEN_W-1:0] new_len;

    assign pix      = s_tdata[23:0];
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;
    assign count    = (pal_count_reg > PAL_LIMIT) ? PAL_LIMIT : pal_count_reg;
    assign max_len  = rle_mode_reg ? MAX_LEN_8BIT : MAX_LEN_4BIT;
    assign extend   = run_open_reg && pix == run_color_reg && run_len_reg < max_len;
    assign final_job = cur_reg || !job_vld_reg[1];

    assign wr.we    = accept && s_tuser;
    assign wr.slot  = s_tdata[27:24];
    assign wr.color = pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rle_mode_reg    <= 1'b0;
            use_trans_reg   <= 1'b0;
            trans_color_reg <= '0;
            pal_count_reg   <= PAL_LIMIT;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_RLE_MODE:    rle_mode_reg    <= cfg_wdata[0];
                REG_USE_TRANS:   use_trans_reg   <= cfg_wdata[0];
                REG_TRANS_COLOR: trans_color_reg <= cfg_wdata;
                REG_PAL_COUNT:   pal_count_reg   <= cfg_wdata[IDX_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        run_color_next = run_color_reg;
        run_len_next   = run_len_reg;
        run_open_next  = run_open_reg;
        job_col_next   = job_col_reg;
        job_len_next   = job_len_reg;
        job_vld_next   = job_vld_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_loi_next   = out_loi_reg;
        out_eos_next   = out_eos_reg;
        s_tready       = 1'b0;
        inj            = '0;
        inj.rgb        = job_col_reg[cur_reg];
        inj.best_w     = WEIGHT_START;
        new_col        = pix;
        new_len        = 8'd1;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept && !s_tuser) begin
                    if (extend) begin
                        new_col = run_color_reg;
                        new_len = run_len_reg + 8'd1;
                    end
                    job_col_next[0] = run_color_reg;
                    job_len_next[0] = run_len_reg;
                    job_col_next[1] = new_col;
                    job_len_next[1] = new_len;
                    job_vld_next    = {s_tlast, run_open_reg && !extend};
                    cur_next        = !(run_open_reg && !extend);
                    if (s_tlast) begin
                        run_open_next = 1'b0;
                        run_len_next  = '0;
                    end else begin
                        run_open_next = 1'b1;
                        run_len_next  = new_len;
                    end
                    run_color_next = new_col;
                    if (s_tlast || (run_open_reg && !extend)) begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                if (use_trans_reg && job_col_reg[cur_reg] == trans_color_reg) begin
                    idx_next   = '0;
                    state_next = ST_LEN;
                end else begin
                    inj.vld    = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (res.vld) begin
                    idx_next   = res.best_idx;
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                if (out_free) begin
                    out_vld_next = 1'b1;
                    if (rle_mode_reg) begin
                        out_byte_next = job_len_reg[cur_reg];
                        out_loi_next  = 1'b0;
                        out_eos_next  = 1'b0;
                        state_next    = ST_IDX;
                    end else begin
                        out_byte_next = {job_len_reg[cur_reg][3:0], idx_reg};
                        out_loi_next  = final_job;
                        out_eos_next  = cur_reg;
                        if (final_job) begin
                            state_next = ST_IDLE;
                        end else begin
                            cur_next   = 1'b1;
                            state_next = ST_START;
                        end
                    end
                end
            end
            ST_IDX: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_byte_next = {{(8-IDX_W){1'b0}}, idx_reg};
                    out_loi_next  = final_job;
                    out_eos_next  = cur_reg;
                    if (final_job) begin
                        state_next = ST_IDLE;
                    end else begin
                        cur_next   = 1'b1;
                        state_next = ST_START;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            run_color_reg <= '0;
            run_len_reg   <= '0;
            run_open_reg  <= 1'b0;
            job_vld_reg   <= '0;
            cur_reg       <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            run_color_reg <= run_color_next;
            run_len_reg   <= run_len_next;
            run_open_reg  <= run_open_next;
            job_vld_reg   <= job_vld_next;
            cur_reg       <= cur_next;
            out_vld_reg   <= out_vld_next;
        end
        job_col_reg  <= job_col_next;
        job_len_reg  <= job_len_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        out_loi_reg  <= out_loi_next;
        out_eos_reg  <= out_eos_next;
    end

    pqr_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .count    (count),
        .wr       (wr),
        .srch_in  (inj),
        .srch_out (res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_loi_reg;
    assign m_tlast  = out_eos_reg;

endmodule
`default_nettype wire

### rtl/pqr_checker.sv
// Port-level checks for the encoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pqr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // a beat that ends the sprite also ends its item
    a_eos_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("end of sprite without last of item");

    // palette write frees the input at once
    a_pal_write_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> s_tready)
        else $error("palette write stalled input");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output beat changed");

endmodule

bind palette_quantize_rle_encoder pqr_checker u_pqr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

### tb/palette_quantize_rle_encoder_tb.sv
// Testbench for the palette quantize run-length encoder: directed and random beats, scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module palette_quantize_rle_encoder_tb;
    import pqr_pkg::*;

    typedef struct {
        logic [7:0] out_byte;
        logic       item_end;
        logic       sprite_end;
    } enc_byte_t;

    // Predicts the encoded byte stream and checks the bytes the block returns.
    class rle_scoreboard;
        logic             wide_len;
        logic             trans_en;
        logic [23:0]      trans_rgb;
        logic [3:0]       search_cnt;
        logic [23:0]      pal [1:15];
        logic [23:0]      cur_rgb;
        logic [7:0]       cur_len;
        logic             cur_open;
        enc_byte_t        expected_bytes[$];
        int               errors;

        function new();
            wide_len = 0; trans_en = 0; trans_rgb = 0; search_cnt = 4'd15;
            cur_rgb = 0; cur_len = 0; cur_open = 0; errors = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [23:0] v);
            case (r)
                REG_RLE_MODE:    wide_len = v[0];
                REG_USE_TRANS:   trans_en = v[0];
                REG_TRANS_COLOR: trans_rgb = v;
                REG_PAL_COUNT:   search_cnt = v[3:0];
                default:         ;
            endcase
        endfunction

        function int chan_diff(logic [7:0] a, logic [7:0] b);
            return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        endfunction

        function logic [7:0] nearest_slot(logic [23:0] rgb);
            int best_w;
            int w;
            logic [7:0] best;
            best = 8'd0;
            best_w = 256 * 4;
            if (trans_en && rgb == trans_rgb) return 8'd0;
            for (int i = 1; i <= int'(search_cnt); i++) begin
                w = chan_diff(pal[i][23:16], rgb[23:16]) + chan_diff(pal[i][15:8], rgb[15:8])
                    + chan_diff(pal[i][7:0], rgb[7:0]);
                if (w < best_w) begin
                    best_w = w;
                    best = 8'(i);
                end
            end
            return best;
        endfunction

        function void queue_byte(logic [7:0] b, logic ie, logic se);
            enc_byte_t e;
            e.out_byte = b;
            e.item_end = ie;
            e.sprite_end = se;
            expected_bytes.insert(expected_bytes.size(), e);
        endfunction

        function void push_run(logic eos);
            logic [7:0] idx;
            idx = nearest_slot(cur_rgb);
            if (wide_len) begin
                queue_byte(cur_len, 1'b0, 1'b0);
                queue_byte(idx, 1'b0, eos);
            end else begin
                queue_byte({cur_len[3:0], idx[3:0]}, 1'b0, eos);
            end
        endfunction

        function void note_beat(logic pal_wr, logic [23:0] rgb, logic [3:0] slot, logic last);
            int before_cnt;
            logic [7:0] max_len;
            if (pal_wr) begin
                if (slot != 0) pal[slot] = rgb;
                return;
            end
            before_cnt = expected_bytes.size();
            max_len = wide_len ? MAX_LEN_8BIT : MAX_LEN_4BIT;
            if (cur_open && rgb == cur_rgb && cur_len < max_len) begin
                cur_len++;
            end else begin
                if (cur_open) push_run(1'b0);
                cur_rgb = rgb;
                cur_len = 1;
                cur_open = 1;
            end
            if (last) begin
                push_run(1'b1);
                cur_open = 0;
                cur_len = 0;
            end
            if (expected_bytes.size() > before_cnt)
                expected_bytes[expected_bytes.size() - 1].item_end = 1'b1;
        endfunction

        function void check_byte(logic [7:0] b, logic ie, logic se);
            enc_byte_t e;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %h item_end %b sprite_end %b", $time, b, ie, se);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            if (b !== e.out_byte) begin
                $display("%0t: out_byte expected %h actual %h", $time, e.out_byte, b);
                errors++;
            end
            if (ie !== e.item_end) begin
                $display("%0t: last_of_item expected %b actual %b", $time, e.item_end, ie);
                errors++;
            end
            if (se !== e.sprite_end) begin
                $display("%0t: end_of_sprite expected %b actual %b", $time, e.sprite_end, se);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 0;
    cfg_reg_t    cfg_addr = REG_RLE_MODE;
    logic [23:0] cfg_wdata = 0;

    rle_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    logic [23:0] prev_rgb = 0;

    palette_quantize_rle_encoder i_dut (.*);

    initial forever #1 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Receiver: random backpressure, or a long hold-off when requested.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tuser, m_tlast);
    end

    task automatic send_beat(logic pal_wr, logic [23:0] rgb, logic [3:0] slot, logic last);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'h0, slot, rgb};
        s_tuser <= pal_wr;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(pal_wr, rgb, slot, last);
    endtask

    // Drain expected bytes, then give the pipeline time to finish a silent run.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [23:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(r, v);
    endtask

    task automatic set_regs(logic m, logic t, logic [23:0] tc, logic [3:0] cnt);
        write_reg(REG_RLE_MODE, {23'd0, m});
        write_reg(REG_USE_TRANS, {23'd0, t});
        write_reg(REG_TRANS_COLOR, tc);
        write_reg(REG_PAL_COUNT, {20'd0, cnt});
        @(posedge aclk);
    endtask

    task automatic random_beat();
        logic [23:0] rgb;
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            send_beat(1'b1, 24'($urandom), 4'($urandom_range(15)), 1'($urandom));
            return;
        end
        pick = $urandom_range(99);
        if (pick < 60) rgb = prev_rgb;
        else if (pick < 75) rgb = sb.pal[$urandom_range(15, 1)];
        else if (pick < 85) rgb = sb.trans_rgb;
        else rgb = 24'($urandom);
        prev_rgb = rgb;
        send_beat(1'b0, rgb, 4'($urandom_range(15)), $urandom_range(99) < 6);
    endtask

    task automatic run_phase(int idle, int stall, logic m, logic t, logic [23:0] tc,
                             logic [3:0] cnt, int beats, bit squeeze);
        wait_drained();
        set_regs(m, t, tc, cnt);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        if (squeeze) hold_left = 400;
        for (int k = 0; k < beats; k++) begin
            // long runs now and then, mostly short ones
            if ($urandom_range(99) < 1)
                repeat ($urandom_range(30, 16)) send_beat(1'b0, prev_rgb, 4'd0, 1'b0);
            random_beat();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill the whole palette before any search can touch it
        for (int i = 1; i <= 15; i++)
            send_beat(1'b1, (i == 1) ? 24'h000000 : (i == 15) ? 24'hFFFFFF : 24'($urandom),
                      4'(i), 1'b0);
        send_beat(1'b1, 24'hABCDEF, 4'd0, 1'b1);
        send_beat(1'b0, 24'h000000, 4'd15, 1'b1);
        repeat (17) send_beat(1'b0, 24'hFFFFFF, 4'd0, 1'b0);
        send_beat(1'b0, 24'h808080, 4'd0, 1'b1);
        // change the length mode under an open run
        wait_drained();
        set_regs(1'b1, 1'b0, 24'h0, 4'd15);
        repeat (20) send_beat(1'b0, 24'h00FF00, 4'd0, 1'b0);
        wait_drained();
        set_regs(1'b0, 1'b0, 24'h0, 4'd15);
        send_beat(1'b0, 24'h00FF00, 4'd0, 1'b1);

        run_phase(0, 0, 1'b0, 1'b0, 24'h000000, 4'd15, 45, 0);
        run_phase(65, 0, 1'b1, 1'b1, 24'hFFFFFF, 4'd15, 45, 0);
        run_phase(0, 65, 1'b0, 1'b1, 24'h000000, 4'd0, 45, 0);
        run_phase(31, 31, 1'b1, 1'b0, 24'h123456, 4'd1, 45, 0);
        run_phase(0, 0, 1'b0, 1'b1, sb.pal[3], 4'd7, 45, 1);
        run_phase(65, 0, 1'b1, 1'b1, 24'($urandom), 4'd15, 45, 0);
        run_phase(0, 65, 1'b0, 1'b0, 24'($urandom), 4'd3, 45, 0);
        run_phase(31, 31, 1'b1, 1'b1, sb.pal[9], 4'd8, 45, 0);
        send_beat(1'b0, prev_rgb, 4'd0, 1'b1);
        wait_drained();

        if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
